/* rtl/utf8_stream_decoder_unit_macros.svh */
// Assertion macros shared by the UTF-8 stream decoder RTL.
// No dependencies; included by u8sd_back, which checks its own logic.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define U8SD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8sd check failed");
// next-cycle implication, checked out of reset
`define U8SD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8sd check failed");
`else
`define U8SD_ASSERT_IMP(label, clk, rst, ante, cons)
`define U8SD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/u8sd_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; used by front, queue, back and top level.
package u8sd_pkg;

  localparam int CP_W            = 21;
  localparam int U8SD_QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_TWO   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;

  // One decoded byte's worth of work: a burst of replacements, then an
  // optional tail result. Never pushed empty.
  typedef struct packed {
    logic [2:0]      repl_cnt;
    logic            tail_vld;
    logic [CP_W-1:0] tail_cp;
    logic            tail_repl;
    logic            eot;
  } cmd_t;

endpackage

/* rtl/utf8_stream_decoder_unit.sv */
// Top level of the UTF-8 stream decoder with U+FFFD replacement.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte; tlast: end_of_text
//  m_*     | out | m_tvalid/m_tready  | tdata: code_point; tlast: last_of_run;
//          |     |                    | tuser: is_replacement, text_done
//
// One byte request is taken per cycle while the command queue has room.
// Each request yields zero to four results; the back end sends one result
// per cycle while m_tready allows, so a byte with k results holds the back
// end until all k are sent, and the queue soaks up error bursts. Results
// pass through the queue, then the registered output stage. rst clears the
// decode state, the queue and the output stage; there is no clearing pass.
// Either side may stall without stopping the other until the queue fills.
module utf8_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = u8sd_pkg::U8SD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tlast,   // last_of_run
  output logic [1:0]  m_tuser    // [0] is_replacement, [1] text_done
);
  import u8sd_pkg::*;

  // front -> queue
  logic push_vld, push_rdy;
  cmd_t push_cmd;
  // queue -> back
  logic pop_vld, pop_rdy;
  cmd_t pop_cmd;

  // classify each byte and fold it into the pending sequence
  u8sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .push_cmd (push_cmd)
  );

  // decouples byte intake from result bursts
  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .push_cmd (push_cmd),
    .pop_vld  (pop_vld),
    .pop_rdy  (pop_rdy),
    .pop_cmd  (pop_cmd)
  );

  // expand commands into results, one per cycle while the output is not stalled, registered out
  u8sd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_vld  (pop_vld),
    .pop_rdy  (pop_rdy),
    .pop_cmd  (pop_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* rtl/u8sd_front.sv */
// Front end: accepts bytes, tracks the pending sequence, emits commands.
// Depends on u8sd_pkg.
module u8sd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  output logic            push_vld,
  input  logic            push_rdy,
  output u8sd_pkg::cmd_t  push_cmd
);
  import u8sd_pkg::*;

  logic [CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]      bytes_needed, bytes_needed_next;
  logic [1:0]      bytes_seen, bytes_seen_next;

  logic            accept;
  logic            is_cont;
  logic [CP_W-1:0] acc;
  logic [1:0]      seen_inc;
  logic [CP_W-1:0] minimum;
  logic            bad;
  logic            f_tail_vld, f_tail_repl;
  logic [CP_W-1:0] f_tail_cp, f_bits;
  logic [1:0]      f_needed;
  cmd_t            cmd;

  assign s_tready = push_rdy;
  assign accept   = s_tvalid && s_tready;
  assign is_cont  = (s_tdata[7:6] == 2'b10);
  assign acc      = {partial_value[CP_W-7:0], s_tdata[5:0]};
  assign seen_inc = bytes_seen + 2'd1;

  always_comb begin
    case (bytes_needed)
      2'd1:    minimum = MIN_TWO;
      2'd2:    minimum = MIN_THREE;
      default: minimum = MIN_FOUR;
    endcase
  end

  assign bad = (acc < minimum) || (acc > CP_MAX) || ((acc >= SURR_LO) && (acc <= SURR_HI));

  // decode of a byte that starts afresh: none pending, or one breaking the pending sequence
  always_comb begin
    f_tail_vld  = 1'b0;
    f_tail_repl = 1'b0;
    f_tail_cp   = REPL_CP;
    f_needed    = 2'd0;
    f_bits      = '0;
    if (!s_tdata[7]) begin
      f_tail_vld = 1'b1;
      f_tail_cp  = {13'b0, s_tdata};
    end else if (s_tdata[7:5] == 3'b110) begin
      f_needed = 2'd1;
      f_bits   = {16'b0, s_tdata[4:0]};
    end else if (s_tdata[7:4] == 4'b1110) begin
      f_needed = 2'd2;
      f_bits   = {17'b0, s_tdata[3:0]};
    end else if (s_tdata[7:3] == 5'b11110) begin
      f_needed = 2'd3;
      f_bits   = {18'b0, s_tdata[2:0]};
    end else begin
      f_tail_vld  = 1'b1;
      f_tail_repl = 1'b1;
    end
    // lead cut short by end of text
    if ((f_needed != 2'd0) && s_tlast) begin
      f_tail_vld  = 1'b1;
      f_tail_repl = 1'b1;
    end
  end

  always_comb begin
    cmd                = '0;
    cmd.eot            = s_tlast;
    cmd.tail_cp        = REPL_CP;
    partial_value_next = partial_value;
    bytes_needed_next  = bytes_needed;
    bytes_seen_next    = bytes_seen;
    if ((bytes_needed != 2'd0) && is_cont) begin
      partial_value_next = acc;
      bytes_seen_next    = seen_inc;
      if (seen_inc >= bytes_needed) begin
        if (bad) begin
          cmd.repl_cnt = {1'b0, bytes_needed} + 3'd1;
        end else begin
          cmd.tail_vld = 1'b1;
          cmd.tail_cp  = acc;
        end
        bytes_needed_next = 2'd0;
        bytes_seen_next   = 2'd0;
      end else if (s_tlast) begin
        cmd.repl_cnt = {1'b0, seen_inc} + 3'd1;
      end
    end else begin
      // broken sequence flushes lead plus held continuations
      if (bytes_needed != 2'd0) begin
        cmd.repl_cnt = {1'b0, bytes_seen} + 3'd1;
      end
      cmd.tail_vld       = f_tail_vld;
      cmd.tail_cp        = f_tail_cp;
      cmd.tail_repl      = f_tail_repl;
      bytes_needed_next  = f_needed;
      partial_value_next = f_bits;
      bytes_seen_next    = 2'd0;
    end
    if (s_tlast) begin
      bytes_needed_next = 2'd0;
      bytes_seen_next   = 2'd0;
    end
  end

  assign push_cmd = cmd;
  assign push_vld = accept && ((cmd.repl_cnt != 3'd0) || cmd.tail_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed <= 2'd0;
      bytes_seen   <= 2'd0;
    end else if (accept) begin
      bytes_needed <= bytes_needed_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      partial_value <= partial_value_next;
    end
  end

endmodule

/* rtl/u8sd_queue.sv */
// Small flop FIFO of commands between front and back end.
// Depends on u8sd_pkg.
module u8sd_queue #(
  parameter int DEPTH = u8sd_pkg::U8SD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_vld,
  output logic            push_rdy,
  input  u8sd_pkg::cmd_t  push_cmd,
  output logic            pop_vld,
  input  logic            pop_rdy,
  output u8sd_pkg::cmd_t  pop_cmd
);
  import u8sd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_rdy = (count != CNT_W'(DEPTH));
  assign pop_vld  = (count != '0);
  assign pop_cmd  = entries[rd_ptr];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/u8sd_back.sv */
// Back end: expands one command into its results, one per cycle while m_tready
// allows, into a registered output stage. Depends on u8sd_pkg and the macro header.
`include "utf8_stream_decoder_unit_macros.svh"

module u8sd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_vld,
  output logic                      pop_rdy,
  input  u8sd_pkg::cmd_t            pop_cmd,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,
  output logic                      m_tlast,
  output logic [1:0]                m_tuser
);
  import u8sd_pkg::*;

  logic [1:0]      idx;
  logic [2:0]      total;
  logic            is_last;
  logic            item_is_repl;
  logic            load;
  logic            out_vld;
  logic [CP_W-1:0] out_cp;
  logic            out_repl, out_last, out_done;

  assign total        = pop_cmd.repl_cnt + {2'b0, pop_cmd.tail_vld};
  assign is_last      = (({1'b0, idx} + 3'd1) == total);
  assign item_is_repl = ({1'b0, idx} < pop_cmd.repl_cnt);
  assign load         = pop_vld && (!out_vld || m_tready);
  assign pop_rdy      = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= 2'd0;
      out_vld <= 1'b0;
    end else begin
      if (load) begin
        out_vld <= 1'b1;
        idx     <= is_last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp   <= item_is_repl ? REPL_CP : pop_cmd.tail_cp;
      out_repl <= item_is_repl ? 1'b1 : pop_cmd.tail_repl;
      out_last <= is_last;
      out_done <= is_last && pop_cmd.eot;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {3'b0, out_cp};
  assign m_tlast  = out_last;
  assign m_tuser  = {out_done, out_repl};

  // mid-burst the command must still sit at the queue head
  `U8SD_ASSERT_IMP(a_head_held, clk, rst, idx != 2'd0, pop_vld)
  // end of text only ever closes a byte's run
  `U8SD_ASSERT_IMP(a_done_on_last, clk, rst, out_vld && out_done, out_last)
  // a good result is a Unicode scalar value
  `U8SD_ASSERT_IMP(a_scalar_ok, clk, rst, out_vld && !out_repl,
                   (out_cp <= CP_MAX) && ((out_cp < SURR_LO) || (out_cp > SURR_HI)))
  // a finished command leaves the burst counter at zero
  `U8SD_ASSERT_NXT(a_idx_clear, clk, rst, pop_rdy, idx == 2'd0)

endmodule
